// ===== hdl/dmx_rdm_frame_receiver_macros.svh =====
// Assertion macros shared by the receiver RTL.
`ifndef DMX_RDM_FRAME_RECEIVER_MACROS_SVH
`define DMX_RDM_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DMXRDM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DMXRDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dmxrdm_pkg.sv =====
// Types and constants of the DMX512/RDM frame receiver.
package dmxrdm_pkg;

  localparam logic [9:0] MAX_FRAME = 10'd513;

  localparam logic [7:0] BREAK_BYTE     = 8'hC0;
  localparam logic [7:0] ESCAPE_BYTE    = 8'hDB;
  localparam logic [7:0] ESCAPED_BREAK  = 8'hDC;
  localparam logic [7:0] ESCAPED_ESCAPE = 8'hDD;
  localparam logic [7:0] RDM_CODE       = 8'hCC;
  localparam logic [7:0] DISC_CODE      = 8'hFE;

  localparam logic [1:0] KIND_DMX   = 2'd0;
  localparam logic [1:0] KIND_RDM   = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  localparam logic [1:0] CFG_RAW_RESPONSE = 2'd0;
  localparam logic [1:0] CFG_INPUT_BLOCK  = 2'd1;
  localparam logic [1:0] CFG_MIN_SLOTS    = 2'd2;

  localparam logic [9:0] MIN_SLOTS_RESET = 10'd24;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RECV = 2'd1,
    MODE_ESC  = 2'd2
  } rx_mode_t;

  typedef struct packed {
    logic       raw_response_mode;
    logic       input_blocked;
    logic [9:0] min_slots;
  } rx_config_t;

  typedef struct packed {
    rx_mode_t   mode;
    logic [9:0] slot_position;
    logic [9:0] expected_length;
    logic [7:0] start_code;
    logic [7:0] rdm_length_byte;
  } rx_state_t;

  typedef struct packed {
    logic       slot_valid;
    logic [9:0] slot_index;
    logic [7:0] slot_value;
    logic       frame_done;
    logic [1:0] frame_kind;
    logic [9:0] frame_count;
  } rx_result_t;

endpackage

// ===== hdl/dmxrdm_step.sv =====
// Per-byte decode: SLIP unescape, slot tracking and frame end detection.
module dmxrdm_step (
  input  dmxrdm_pkg::rx_config_t cfg,
  input  dmxrdm_pkg::rx_state_t  cur,
  input  logic [7:0]             rx_byte,
  output dmxrdm_pkg::rx_state_t  nxt,
  output dmxrdm_pkg::rx_result_t res
);

  logic       active;
  logic       is_break;
  logic       store_req;
  logic [7:0] store_val;
  logic       skip_zero;
  logic       store_eff;
  logic       write_slot;
  logic       at_len_slot;
  logic [9:0] slot_after;
  logic [9:0] exp_after;
  logic [7:0] start_after;
  logic [7:0] rdm_after;
  logic       unknown_code;
  logic       end_by_len;
  logic       end_by_break;
  logic       finish;

  assign active   = !cfg.input_blocked;
  assign is_break = active && (rx_byte == dmxrdm_pkg::BREAK_BYTE);

  // Decode the byte into a store request with its unescaped value.
  always_comb begin
    store_req = 1'b0;
    store_val = rx_byte;
    if (active && !is_break) begin
      case (cur.mode)
        dmxrdm_pkg::MODE_RECV: begin
          store_req = (rx_byte != dmxrdm_pkg::ESCAPE_BYTE);
        end
        dmxrdm_pkg::MODE_ESC: begin
          if (rx_byte == dmxrdm_pkg::ESCAPED_BREAK) begin
            store_req = 1'b1;
            store_val = dmxrdm_pkg::BREAK_BYTE;
          end else if (rx_byte == dmxrdm_pkg::ESCAPED_ESCAPE) begin
            store_req = 1'b1;
            store_val = dmxrdm_pkg::ESCAPE_BYTE;
          end
        end
        default: begin
          store_req = 1'b0;
        end
      endcase
    end
  end

  assign skip_zero   = (cur.slot_position == 10'd0) && cfg.raw_response_mode &&
                       (store_val == 8'd0);
  assign store_eff   = store_req && !skip_zero;
  assign write_slot  = store_eff && (cur.slot_position < dmxrdm_pkg::MAX_FRAME);
  assign at_len_slot = write_slot && (cur.slot_position == 10'd2);
  assign slot_after  = write_slot ? cur.slot_position + 10'd1 : cur.slot_position;
  assign start_after = (write_slot && cur.slot_position == 10'd0) ? store_val
                                                                  : cur.start_code;
  assign rdm_after   = at_len_slot ? store_val : cur.rdm_length_byte;

  always_comb begin
    exp_after = cur.expected_length;
    if (at_len_slot) begin
      if (cur.start_code == dmxrdm_pkg::RDM_CODE) begin
        if (!cfg.raw_response_mode) begin
          exp_after = {2'b00, store_val} + 10'd2;
        end
      end else if (cur.start_code == dmxrdm_pkg::DISC_CODE) begin
        exp_after = dmxrdm_pkg::MAX_FRAME;
      end
    end
  end

  assign unknown_code = at_len_slot && (cur.start_code != dmxrdm_pkg::RDM_CODE) &&
                        (cur.start_code != dmxrdm_pkg::DISC_CODE) &&
                        (cur.start_code != 8'd0);
  assign end_by_len   = store_eff && (slot_after >= exp_after);
  assign end_by_break = is_break && (cur.mode == dmxrdm_pkg::MODE_RECV) &&
                        (cur.slot_position > 10'd1) && (cur.start_code == 8'd0);
  assign finish       = end_by_len || end_by_break;

  // Next state.
  always_comb begin
    nxt                 = cur;
    nxt.slot_position   = slot_after;
    nxt.expected_length = exp_after;
    nxt.start_code      = start_after;
    nxt.rdm_length_byte = rdm_after;
    if (is_break) begin
      nxt.mode            = dmxrdm_pkg::MODE_RECV;
      nxt.expected_length = dmxrdm_pkg::MAX_FRAME;
      if (!cfg.raw_response_mode) begin
        nxt.slot_position = 10'd0;
      end
    end else if (active) begin
      case (cur.mode)
        dmxrdm_pkg::MODE_RECV: begin
          if (rx_byte == dmxrdm_pkg::ESCAPE_BYTE) begin
            nxt.mode = dmxrdm_pkg::MODE_ESC;
          end else if (finish || unknown_code) begin
            nxt.mode = dmxrdm_pkg::MODE_IDLE;
          end
        end
        dmxrdm_pkg::MODE_ESC: begin
          if (finish || unknown_code) begin
            nxt.mode = dmxrdm_pkg::MODE_IDLE;
          end else begin
            nxt.mode = dmxrdm_pkg::MODE_RECV;
          end
        end
        default: begin
          nxt.mode = cur.mode;
        end
      endcase
    end
  end

  // Result of this byte.
  always_comb begin
    res             = '0;
    res.slot_valid  = write_slot;
    res.slot_index  = write_slot ? cur.slot_position : 10'd0;
    res.slot_value  = write_slot ? store_val : 8'd0;
    res.frame_done  = finish;
    if (finish) begin
      if (start_after == 8'd0) begin
        if (!cfg.raw_response_mode && (slot_after > cfg.min_slots)) begin
          res.frame_kind  = dmxrdm_pkg::KIND_DMX;
          res.frame_count = slot_after - 10'd1;
        end else begin
          res.frame_kind  = dmxrdm_pkg::KIND_OTHER;
        end
      end else if (start_after == dmxrdm_pkg::RDM_CODE) begin
        res.frame_kind  = dmxrdm_pkg::KIND_RDM;
        res.frame_count = {2'b00, rdm_after} + 10'd2;
      end else begin
        res.frame_kind  = dmxrdm_pkg::KIND_OTHER;
      end
    end
  end

endmodule

// ===== hdl/dmx_rdm_frame_receiver.sv =====
// Top level of the DMX512/RDM frame receiver: input register, state and result register.
// DMX512/RDM frame receiver. Takes one byte per transfer from a SLIP-framed UART
// stream (0xC0 is a line break, 0xDB escapes the next byte) and returns exactly one
// result per byte: the stored slot with its index, and, when a frame ends, its kind
// (0 DMX, 1 RDM, 2 discarded/unknown) and its slot count or RDM length plus two.
// Each byte is latched in an input register and decoded in one pass into the result
// register and the frame state, so a new byte is taken every cycle unless the input
// stalls. A result leaves the result register on the output transfer. The input
// stalls only while the result register holds a stalled result and another byte
// already waits in the input register.
// Write configuration (0 raw-response mode, 1 input blocked, 2 min slots) only while
// no byte is in flight; the config channel is always ready.
module dmx_rdm_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       slot_valid,
  output logic [9:0] slot_index,
  output logic [7:0] slot_value,
  output logic       frame_done,
  output logic [1:0] frame_kind,
  output logic [9:0] frame_count
);

`include "dmx_rdm_frame_receiver_macros.svh"

  dmxrdm_pkg::rx_config_t cfg;
  dmxrdm_pkg::rx_state_t  state;
  dmxrdm_pkg::rx_state_t  state_next;
  dmxrdm_pkg::rx_result_t result_next;
  dmxrdm_pkg::rx_result_t result;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_response_mode <= 1'b0;
      cfg.input_blocked     <= 1'b0;
      cfg.min_slots         <= dmxrdm_pkg::MIN_SLOTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dmxrdm_pkg::CFG_RAW_RESPONSE: cfg.raw_response_mode <= cfg_data[0];
        dmxrdm_pkg::CFG_INPUT_BLOCK:  cfg.input_blocked     <= cfg_data[0];
        dmxrdm_pkg::CFG_MIN_SLOTS:    cfg.min_slots         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Decode the held byte when the result register can take its result.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  dmxrdm_step u_step (
    .cfg     (cfg),
    .cur     (state),
    .rx_byte (in_byte),
    .nxt     (state_next),
    .res     (result_next)
  );

  // Frame state: advance once per decoded byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode            <= dmxrdm_pkg::MODE_IDLE;
      state.slot_position   <= 10'd0;
      state.expected_length <= dmxrdm_pkg::MAX_FRAME;
      state.start_code      <= 8'd0;
      state.rdm_length_byte <= 8'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: load on decode, drop after the output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign slot_valid  = result.slot_valid;
  assign slot_index  = result.slot_index;
  assign slot_value  = result.slot_value;
  assign frame_done  = result.frame_done;
  assign frame_kind  = result.frame_kind;
  assign frame_count = result.frame_count;

  `DMXRDM_ASSERT_NOW(a_slot_in_range, 1'b1, state.slot_position <= dmxrdm_pkg::MAX_FRAME, "slot position past frame maximum")
  `DMXRDM_ASSERT_NOW(a_index_in_range, out_valid && slot_valid, slot_index < dmxrdm_pkg::MAX_FRAME, "stored slot index out of range")
  `DMXRDM_ASSERT_NOW(a_other_no_count, out_valid && frame_done && frame_kind == dmxrdm_pkg::KIND_OTHER, frame_count == 10'd0, "discarded frame carries a count")
  `DMXRDM_ASSERT_NEXT(a_hold_input, in_full && !advance, in_full && $stable(in_byte), "held byte lost while result stalled")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the DMX512/RDM frame receiver: directed rows, then random frames.
module testbench;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int PHASE_ITEMS    = 100;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int IDLE_PERCENT   = 12;
  localparam int PRINT_LIMIT    = 50;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // One directed step: a received byte or a register write. When typed is set,
  // want holds the result read straight off the frame rules; otherwise the
  // tracker below supplies it.
  typedef struct {
    row_kind_t              kind;
    logic [1:0]             reg_sel;
    logic [9:0]             value;
    bit                     typed;
    dmxrdm_pkg::rx_result_t want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 32;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // byte while idle, then a break that opens reception
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h055, 1'b1, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0C0, 1'b1, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h000, 1'b1,
      '{1'b1, 10'd0, 8'h00, 1'b0, dmxrdm_pkg::KIND_DMX, 10'd0}},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0FF, 1'b1,
      '{1'b1, 10'd1, 8'hFF, 1'b0, dmxrdm_pkg::KIND_DMX, 10'd0}},
    // early break on a short zero-code frame: discarded under the default minimum
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0C0, 1'b1,
      '{1'b0, 10'd0, 8'h00, 1'b1, dmxrdm_pkg::KIND_OTHER, 10'd0}},
    '{ROW_CFG,  dmxrdm_pkg::CFG_MIN_SLOTS,    10'd0,   1'b0, '0},
    // escapes: both valid forms, then an unknown one that is dropped
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h000, 1'b1,
      '{1'b1, 10'd0, 8'h00, 1'b0, dmxrdm_pkg::KIND_DMX, 10'd0}},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0DB, 1'b1, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0DC, 1'b1,
      '{1'b1, 10'd1, 8'hC0, 1'b0, dmxrdm_pkg::KIND_DMX, 10'd0}},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0DB, 1'b0, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0DD, 1'b1,
      '{1'b1, 10'd2, 8'hDB, 1'b0, dmxrdm_pkg::KIND_DMX, 10'd0}},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0DB, 1'b0, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h041, 1'b1, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0C0, 1'b1,
      '{1'b0, 10'd0, 8'h00, 1'b1, dmxrdm_pkg::KIND_DMX, 10'd2}},
    // RDM packet whose length byte is below two ends right after slot 2
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0CC, 1'b1,
      '{1'b1, 10'd0, 8'hCC, 1'b0, dmxrdm_pkg::KIND_DMX, 10'd0}},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h001, 1'b0, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h000, 1'b1,
      '{1'b1, 10'd2, 8'h00, 1'b1, dmxrdm_pkg::KIND_RDM, 10'd2}},
    // unknown start code: slot 2 still comes out, then the block idles
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0C0, 1'b0, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h017, 1'b0, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h000, 1'b0, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h005, 1'b1,
      '{1'b1, 10'd2, 8'h05, 1'b0, dmxrdm_pkg::KIND_DMX, 10'd0}},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h033, 1'b1, '0},
    // raw response: leading zero skipped
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0C0, 1'b0, '0},
    '{ROW_CFG,  dmxrdm_pkg::CFG_RAW_RESPONSE, 10'd1,   1'b0, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h000, 1'b1, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0FE, 1'b1,
      '{1'b1, 10'd0, 8'hFE, 1'b0, dmxrdm_pkg::KIND_DMX, 10'd0}},
    '{ROW_CFG,  dmxrdm_pkg::CFG_RAW_RESPONSE, 10'd0,   1'b0, '0},
    // blocked input: everything ignored
    '{ROW_CFG,  dmxrdm_pkg::CFG_INPUT_BLOCK,  10'd1,   1'b0, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h0C0, 1'b1, '0},
    '{ROW_BYTE, dmxrdm_pkg::CFG_RAW_RESPONSE, 10'h000, 1'b1, '0},
    '{ROW_CFG,  dmxrdm_pkg::CFG_INPUT_BLOCK,  10'd0,   1'b0, '0},
    '{ROW_CFG,  dmxrdm_pkg::CFG_MIN_SLOTS,    dmxrdm_pkg::MIN_SLOTS_RESET, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       slot_valid;
  logic [9:0] slot_index;
  logic [7:0] slot_value;
  logic       frame_done;
  logic [1:0] frame_kind;
  logic [9:0] frame_count;

  // Mirror of the block's registers and frame state, advanced once per
  // accepted byte.
  dmxrdm_pkg::rx_config_t cfg_mirror;
  dmxrdm_pkg::rx_state_t  rx_track;
  dmxrdm_pkg::rx_result_t awaited_slot_results [$];

  int mismatches   = 0;
  int counted_rx   = 0;
  int idle_cycles  = 0;
  bit no_idle      = 1'b0;
  bit hold_request = 1'b0;
  bit hold_taken   = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  dmx_rdm_frame_receiver DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot_valid  (slot_valid),
    .slot_index  (slot_index),
    .slot_value  (slot_value),
    .frame_done  (frame_done),
    .frame_kind  (frame_kind),
    .frame_count (frame_count)
  );

  // ---------------------------------------------------------------------------
  // Frame tracker
  // ---------------------------------------------------------------------------

  // Close the current frame: classify it and drop back to idle.
  function automatic void close_frame(inout dmxrdm_pkg::rx_result_t r);
    r.frame_done  = 1'b1;
    r.frame_count = '0;
    if (rx_track.start_code == 8'h00) begin
      if (!cfg_mirror.raw_response_mode &&
          rx_track.slot_position > cfg_mirror.min_slots) begin
        r.frame_kind  = dmxrdm_pkg::KIND_DMX;
        r.frame_count = rx_track.slot_position - 10'd1;
      end else begin
        r.frame_kind = dmxrdm_pkg::KIND_OTHER;
      end
    end else if (rx_track.start_code == dmxrdm_pkg::RDM_CODE) begin
      r.frame_kind  = dmxrdm_pkg::KIND_RDM;
      r.frame_count = {2'b00, rx_track.rdm_length_byte} + 10'd2;
    end else begin
      r.frame_kind = dmxrdm_pkg::KIND_OTHER;
    end
    rx_track.mode = dmxrdm_pkg::MODE_IDLE;
  endfunction

  // Store one unescaped byte at the current slot, then run the length test.
  function automatic void store_slot(input logic [7:0] v,
                                     inout dmxrdm_pkg::rx_result_t r);
    if (rx_track.slot_position == 10'd0 && cfg_mirror.raw_response_mode && v == 8'h00)
      return;
    if (rx_track.slot_position < dmxrdm_pkg::MAX_FRAME) begin
      r.slot_valid = 1'b1;
      r.slot_index = rx_track.slot_position;
      r.slot_value = v;
      if (rx_track.slot_position == 10'd0)
        rx_track.start_code = v;
      if (rx_track.slot_position == 10'd2) begin
        rx_track.rdm_length_byte = v;
        if (rx_track.start_code == dmxrdm_pkg::RDM_CODE) begin
          if (!cfg_mirror.raw_response_mode)
            rx_track.expected_length = {2'b00, v} + 10'd2;
        end else if (rx_track.start_code == dmxrdm_pkg::DISC_CODE) begin
          rx_track.expected_length = dmxrdm_pkg::MAX_FRAME;
        end else if (rx_track.start_code != 8'h00) begin
          rx_track.mode = dmxrdm_pkg::MODE_IDLE;
        end
      end
      rx_track.slot_position = rx_track.slot_position + 10'd1;
    end
    if (rx_track.slot_position >= rx_track.expected_length)
      close_frame(r);
  endfunction

  // Advance the tracker by one received byte and return the result it causes.
  function automatic dmxrdm_pkg::rx_result_t decode_rx_byte(input logic [7:0] c);
    dmxrdm_pkg::rx_result_t r;
    r = '0;
    if (!cfg_mirror.input_blocked) begin
      if (c == dmxrdm_pkg::BREAK_BYTE) begin
        if (rx_track.mode == dmxrdm_pkg::MODE_RECV && rx_track.slot_position > 10'd1 &&
            rx_track.start_code == 8'h00)
          close_frame(r);
        rx_track.mode = dmxrdm_pkg::MODE_RECV;
        if (!cfg_mirror.raw_response_mode)
          rx_track.slot_position = '0;
        rx_track.expected_length = dmxrdm_pkg::MAX_FRAME;
      end else if (rx_track.mode == dmxrdm_pkg::MODE_RECV) begin
        if (c == dmxrdm_pkg::ESCAPE_BYTE)
          rx_track.mode = dmxrdm_pkg::MODE_ESC;
        else
          store_slot(c, r);
      end else if (rx_track.mode == dmxrdm_pkg::MODE_ESC) begin
        rx_track.mode = dmxrdm_pkg::MODE_RECV;
        if (c == dmxrdm_pkg::ESCAPED_BREAK)
          store_slot(dmxrdm_pkg::BREAK_BYTE, r);
        else if (c == dmxrdm_pkg::ESCAPED_ESCAPE)
          store_slot(dmxrdm_pkg::ESCAPE_BYTE, r);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks (entered and left at a falling edge)
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until the transfer, and queue its result.
  task automatic send_rx_byte(input logic [7:0] b, input bit typed,
                              input dmxrdm_pkg::rx_result_t want);
    int gap;
    dmxrdm_pkg::rx_result_t predicted;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
      gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (in_stall);
    predicted = decode_rx_byte(b);
    awaited_slot_results.push_back(typed ? want : predicted);
    if (!cfg_mirror.input_blocked)
      counted_rx++;
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_rx_byte(b, 1'b0, '0);
  endtask

  // Send a slot byte in SLIP form: escape the two reserved codes.
  task automatic send_slot_data(input logic [7:0] b);
    if (b == dmxrdm_pkg::BREAK_BYTE) begin
      send_plain(dmxrdm_pkg::ESCAPE_BYTE);
      send_plain(dmxrdm_pkg::ESCAPED_BREAK);
    end else if (b == dmxrdm_pkg::ESCAPE_BYTE) begin
      send_plain(dmxrdm_pkg::ESCAPE_BYTE);
      send_plain(dmxrdm_pkg::ESCAPED_ESCAPE);
    end else begin
      send_plain(b);
    end
  endtask

  // Data byte biased toward the reserved codes and the extremes.
  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return dmxrdm_pkg::BREAK_BYTE;
      1:       return dmxrdm_pkg::ESCAPE_BYTE;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Slot payload with an occasional malformed escape (sometimes a break
  // right after the escape code).
  task automatic send_frame_body(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        send_plain(dmxrdm_pkg::ESCAPE_BYTE);
        send_plain($urandom_range(0, 1) ? dmxrdm_pkg::BREAK_BYTE
                                        : 8'($urandom_range(0, 255)));
      end else begin
        send_slot_data(pick_data());
      end
    end
  endtask

  task automatic send_dmx_frame(input int n);
    send_plain(dmxrdm_pkg::BREAK_BYTE);
    send_plain(8'h00);
    send_frame_body(n);
  endtask

  task automatic send_rdm_packet();
    int len;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 30);
    send_plain(dmxrdm_pkg::BREAK_BYTE);
    send_plain(dmxrdm_pkg::RDM_CODE);
    send_slot_data(pick_data());
    send_slot_data(8'(len));
    send_frame_body((len > 1 ? len - 1 : 0) + $urandom_range(0, 2));
  endtask

  task automatic send_coded_frame(input logic [7:0] code, input int n);
    send_plain(dmxrdm_pkg::BREAK_BYTE);
    send_slot_data(code);
    send_frame_body(n);
  endtask

  // Write one register once no byte is in flight.
  task automatic write_register(input logic [1:0] sel, input logic [9:0] value);
    in_valid = 1'b0;
    while (awaited_slot_results.size() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = sel;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      dmxrdm_pkg::CFG_RAW_RESPONSE: cfg_mirror.raw_response_mode = value[0];
      dmxrdm_pkg::CFG_INPUT_BLOCK:  cfg_mirror.input_blocked     = value[0];
      dmxrdm_pkg::CFG_MIN_SLOTS:    cfg_mirror.min_slots         = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
  endtask

  // Compare every result transfer against the oldest queued expectation.
  always @(posedge clk) begin : check_results
    dmxrdm_pkg::rx_result_t got;
    dmxrdm_pkg::rx_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {slot_valid, slot_index, slot_value, frame_done, frame_kind, frame_count};
      if (awaited_slot_results.size() == 0) begin
        flag_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = awaited_slot_results.pop_front();
        if (got.slot_valid !== want.slot_valid)
          flag_mismatch("slot_valid", got.slot_valid, want.slot_valid);
        if (got.slot_index !== want.slot_index)
          flag_mismatch("slot_index", got.slot_index, want.slot_index);
        if (got.slot_value !== want.slot_value)
          flag_mismatch("slot_value", got.slot_value, want.slot_value);
        if (got.frame_done !== want.frame_done)
          flag_mismatch("frame_done", got.frame_done, want.frame_done);
        if (got.frame_kind !== want.frame_kind)
          flag_mismatch("frame_kind", got.frame_kind, want.frame_kind);
        if (got.frame_count !== want.frame_count)
          flag_mismatch("frame_count", got.frame_count, want.frame_count);
      end
    end
  end

  // Count cycles without any transfer; a stuck handshake ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, or one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        // Hold off long enough for the block to fill and stall its input.
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_taken = 1'b1;
      end else begin
        out_stall = !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic       raw_sel;
    logic       block_sel;
    logic [9:0] min_sel;
    int         phase;
    int         target;
    int         n;

    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = dmxrdm_pkg::CFG_RAW_RESPONSE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    rx_byte   = '0;

    cfg_mirror = '{raw_response_mode: 1'b0, input_blocked: 1'b0,
                   min_slots: dmxrdm_pkg::MIN_SLOTS_RESET};
    rx_track   = '{mode: dmxrdm_pkg::MODE_IDLE, slot_position: '0,
                   expected_length: dmxrdm_pkg::MAX_FRAME,
                   start_code: '0, rdm_length_byte: '0};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed rows.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_register(directed_rows[i].reg_sel, directed_rows[i].value);
      else
        send_rx_byte(directed_rows[i].value[7:0], directed_rows[i].typed,
                     directed_rows[i].want);
    end

    // Random phases: fresh register settings, then a run of frames.
    counted_rx = 0;
    phase      = 0;
    while (counted_rx < RANDOM_ITEMS || phase <= 5) begin
      raw_sel   = ($urandom_range(0, 4) == 0);
      block_sel = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 5))
        0:       min_sel = 10'd0;
        1:       min_sel = 10'd512;
        2:       min_sel = dmxrdm_pkg::MIN_SLOTS_RESET;
        3:       min_sel = 10'($urandom_range(0, 512));
        4:       min_sel = 10'($urandom_range(0, 40));
        default: min_sel = 10'd1;
      endcase
      // Fixed roles for the first phases: a full-length zero-code frame, a
      // plain run, a full discovery frame in raw mode that runs the slot
      // position up to the limit and keeps it there, a stretch with no
      // idling, and the long receiver hold-off.
      if (phase >= 1 && phase <= 5) begin
        block_sel = 1'b0;
        raw_sel   = (phase == 3);
      end
      write_register(dmxrdm_pkg::CFG_RAW_RESPONSE, {9'd0, raw_sel});
      write_register(dmxrdm_pkg::CFG_INPUT_BLOCK,  {9'd0, block_sel});
      write_register(dmxrdm_pkg::CFG_MIN_SLOTS,    min_sel);

      no_idle = (phase == 4);
      if (phase == 5)
        hold_request = 1'b1;

      if (block_sel) begin
        repeat (20) send_plain(pick_data());
      end else begin
        if (phase == 1)
          send_dmx_frame(530);
        else if (phase == 3)
          send_coded_frame(dmxrdm_pkg::DISC_CODE, 520);
        target = counted_rx + ((phase == 1) ? 0 : PHASE_ITEMS);
        while (counted_rx < target) begin
          case ($urandom_range(0, 9))
            0, 1, 2: send_dmx_frame($urandom_range(0, 40));
            3: begin
              // Land near the acceptance boundary of min_slots.
              n = (cfg_mirror.min_slots > 10'd1) ? cfg_mirror.min_slots - 1 : 0;
              if (n < 100)
                send_dmx_frame(n + $urandom_range(0, 2));
              else
                send_dmx_frame($urandom_range(0, 10));
            end
            4, 5: send_rdm_packet();
            6:    send_coded_frame(dmxrdm_pkg::DISC_CODE, $urandom_range(0, 20));
            7:    send_coded_frame(8'($urandom_range(1, 255)), $urandom_range(0, 4));
            8:    repeat ($urandom_range(1, 6)) send_plain(pick_data());
            default: begin
              // Zero-code frame left in the escaped state; a break there does not close it.
              send_dmx_frame($urandom_range(2, 20));
              send_plain(dmxrdm_pkg::ESCAPE_BYTE);
            end
          endcase
        end
      end
      no_idle = 1'b0;
      phase++;
    end

    // Drain, let the pipeline settle, then report.
    in_valid = 1'b0;
    while (awaited_slot_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
